>>> rtl/core/keyed_run_batch_segmenter_macros.svh
// Assertion helpers for keyed_run_batch_segmenter.
// Both expect i_clk and i_rst_n in the scope of use.
`ifndef KEYED_RUN_BATCH_SEGMENTER_MACROS_SVH
`define KEYED_RUN_BATCH_SEGMENTER_MACROS_SVH
`ifndef SYNTHESIS
`define KRBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KRBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KRBS_ASSERT_IMP(lbl, ante, cons, msg)
`define KRBS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/krbs_pkg.sv
`default_nettype none
package krbs_pkg;

    localparam int START_W = 16;
    localparam int LEN_W   = 17;
    localparam int KEY_W   = 64;
    localparam int CFG_W   = 17;

    // one input word gives at most this many batch records
    localparam int SLOTS   = 3;
    localparam int CANDS   = 5;
    localparam int QDEPTH  = 2;

    localparam logic [CFG_W-1:0] MIN_RUN_RESET = 17'd1;

    typedef logic [$clog2(SLOTS)-1:0] t_slot_idx;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               inst;
        logic [KEY_W-1:0]   key;
    } t_batch;

    typedef struct packed {
        t_batch [SLOTS-1:0] slot;
        t_slot_idx          last;
    } t_step;

endpackage
`default_nettype wire

>>> rtl/core/krbs_front.sv
`default_nettype none
module krbs_front #(
    parameter int MAX_ELEMENTS = 65536
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [krbs_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_acc,
    input  wire logic                        i_groupable,
    input  wire logic [krbs_pkg::KEY_W-1:0]  i_group_key,
    input  wire logic                        i_end_of_list,
    output logic                             o_step_vld,
    output krbs_pkg::t_step                  o_step
);

    localparam int AW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW   = (AW + 1 > krbs_pkg::LEN_W) ? AW + 1 : krbs_pkg::LEN_W;
    localparam int CNTW = $clog2(krbs_pkg::CANDS + 1);
    localparam int SIW  = $clog2(krbs_pkg::SLOTS);

    logic [krbs_pkg::CFG_W-1:0] r_min_run;
    logic [AW-1:0]              r_elem_idx;
    logic [AW-1:0]              r_plain_begin;
    logic [AW-1:0]              r_run_begin;
    logic [krbs_pkg::KEY_W-1:0] r_run_key;
    logic                       r_run_open;

    logic [CW-1:0] idx, idx1, need, pb0, rb0, len1, pb1, rb2, len2, pb2;
    logic          eol, brk, emit1, open1, open2, emit2;
    logic [krbs_pkg::KEY_W-1:0] key2;

    krbs_pkg::t_batch [krbs_pkg::CANDS-1:0] cand;
    logic [krbs_pkg::CANDS-1:0]             cand_vld;
    logic [CNTW-1:0]                        cnt;

    function automatic krbs_pkg::t_batch mk_batch(
        input logic [CW-1:0]              start,
        input logic [CW-1:0]              len,
        input logic                       inst,
        input logic [krbs_pkg::KEY_W-1:0] key
    );
        krbs_pkg::t_batch b;
        b.start = start[krbs_pkg::START_W-1:0];
        b.len   = len[krbs_pkg::LEN_W-1:0];
        b.inst  = inst;
        b.key   = inst ? key : '0;
        return b;
    endfunction

    always_comb begin
        idx   = CW'(r_elem_idx);
        idx1  = idx + CW'(1);
        pb0   = CW'(r_plain_begin);
        rb0   = CW'(r_run_begin);
        need  = (r_min_run == '0) ? CW'(1) : CW'(r_min_run);
        eol   = i_end_of_list || (r_elem_idx >= AW'(MAX_ELEMENTS - 1));

        // run broken by this word
        brk   = r_run_open && (!i_groupable || (i_group_key != r_run_key));
        len1  = idx - rb0;
        emit1 = brk && (len1 >= need);
        pb1   = emit1 ? idx : pb0;

        open1 = r_run_open && !brk;
        open2 = open1 || i_groupable;
        rb2   = open1 ? rb0 : idx;
        key2  = open1 ? r_run_key : i_group_key;

        // end of list closes whatever run is open
        len2  = idx1 - rb2;
        emit2 = eol && open2 && (len2 >= need);
        pb2   = emit2 ? idx1 : pb1;

        cand[0]     = mk_batch(pb0, rb0 - pb0, 1'b0, '0);
        cand_vld[0] = emit1 && (rb0 > pb0);
        cand[1]     = mk_batch(rb0, len1, 1'b1, r_run_key);
        cand_vld[1] = emit1;
        cand[2]     = mk_batch(pb1, rb2 - pb1, 1'b0, '0);
        cand_vld[2] = emit2 && (rb2 > pb1);
        cand[3]     = mk_batch(rb2, len2, 1'b1, key2);
        cand_vld[3] = emit2;
        cand[4]     = mk_batch(pb2, idx1 - pb2, 1'b0, '0);
        cand_vld[4] = eol && (idx1 > pb2);
    end

    always_comb begin
        o_step = '0;
        cnt    = '0;
        for (int i = 0; i < krbs_pkg::CANDS; i++) begin
            if (cand_vld[i]) begin
                if (cnt < CNTW'(krbs_pkg::SLOTS)) begin
                    o_step.slot[cnt[SIW-1:0]] = cand[i];
                end
                cnt = cnt + CNTW'(1);
            end
        end
        o_step.last = SIW'(cnt - CNTW'(1));
        o_step_vld  = i_acc && (cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_run     <= krbs_pkg::MIN_RUN_RESET;
            r_elem_idx    <= '0;
            r_plain_begin <= '0;
            r_run_begin   <= '0;
            r_run_key     <= '0;
            r_run_open    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_min_run <= i_cfg_wr_data;
            end
            if (i_acc) begin
                if (eol) begin
                    r_elem_idx    <= '0;
                    r_plain_begin <= '0;
                    r_run_begin   <= '0;
                    r_run_key     <= '0;
                    r_run_open    <= 1'b0;
                end else begin
                    r_elem_idx    <= idx1[AW-1:0];
                    r_plain_begin <= pb1[AW-1:0];
                    r_run_begin   <= rb2[AW-1:0];
                    r_run_key     <= key2;
                    r_run_open    <= open2;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/krbs_fifo.sv
`default_nettype none
module krbs_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_en,
    input  wire krbs_pkg::t_step i_wr_data,
    input  wire logic            i_rd_en,
    output logic                 o_full,
    output logic                 o_vld,
    output krbs_pkg::t_step      o_rd_data
);

    localparam int PW = (krbs_pkg::QDEPTH > 1) ? $clog2(krbs_pkg::QDEPTH) : 1;
    localparam int NW = $clog2(krbs_pkg::QDEPTH + 1);

    krbs_pkg::t_step r_mem [krbs_pkg::QDEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(krbs_pkg::QDEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(krbs_pkg::QDEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_wr_en && !i_rd_en) begin
            n_cnt = r_cnt + NW'(1);
        end else if (!i_wr_en && i_rd_en) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_full    = (r_cnt == NW'(krbs_pkg::QDEPTH));
    assign o_vld     = (r_cnt != '0);
    assign o_rd_data = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

>>> rtl/core/krbs_back.sv
`default_nettype none
module krbs_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step_vld,
    input  wire krbs_pkg::t_step               i_step,
    output logic                               o_step_pop,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic [krbs_pkg::START_W-1:0]       o_batch_start,
    output logic [krbs_pkg::LEN_W-1:0]         o_batch_length,
    output logic                               o_instanced,
    output logic [krbs_pkg::KEY_W-1:0]         o_batch_group_key,
    output logic                               o_last_of_step
);

    krbs_pkg::t_slot_idx r_slot;
    logic                r_out_vld;
    krbs_pkg::t_batch    r_out;
    logic                r_last;

    logic out_take, adv, at_last;

    always_comb begin
        out_take   = i_pop && r_out_vld;
        adv        = i_step_vld && (!r_out_vld || out_take);
        at_last    = (r_slot == i_step.last);
        o_step_pop = adv && at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_out_vld <= 1'b1;
                r_slot    <= at_last ? '0 : r_slot + krbs_pkg::t_slot_idx'(1);
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out  <= i_step.slot[r_slot];
            r_last <= at_last;
        end
    end

    assign o_empty           = !r_out_vld;
    assign o_batch_start     = r_out.start;
    assign o_batch_length    = r_out.len;
    assign o_instanced       = r_out.inst;
    assign o_batch_group_key = r_out.key;
    assign o_last_of_step    = r_last;

endmodule
`default_nettype wire

>>> rtl/core/keyed_run_batch_segmenter.sv
// Splits a list of elements into draw batches: runs of groupable elements with one key that
// reach the minimum run length become instanced batches, everything else is flushed as plain
// stretches with key 0. A word is taken in every cycle while the two-entry step queue has
// room; each word yields zero to three result words, which leave at one per cycle from the
// output register while pop is held. The first result of a word is written to the step
// queue and from there into the output register before it is visible.
`default_nettype none
`include "keyed_run_batch_segmenter_macros.svh"
module keyed_run_batch_segmenter #(
    parameter int MAX_ELEMENTS = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [krbs_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_groupable,
    input  wire logic [krbs_pkg::KEY_W-1:0]    i_group_key,
    input  wire logic                          i_end_of_list,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [krbs_pkg::START_W-1:0]       o_batch_start,
    output logic [krbs_pkg::LEN_W-1:0]         o_batch_length,
    output logic                               o_instanced,
    output logic [krbs_pkg::KEY_W-1:0]         o_batch_group_key,
    output logic                               o_last_of_step
);

    logic            w_in_acc;
    logic            w_q_push;
    krbs_pkg::t_step w_step;
    logic            w_q_vld;
    logic            w_q_pop;
    krbs_pkg::t_step w_q_rec;

    assign w_in_acc = push && !full;

    krbs_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_acc         (w_in_acc),
        .i_groupable   (i_groupable),
        .i_group_key   (i_group_key),
        .i_end_of_list (i_end_of_list),
        .o_step_vld    (w_q_push),
        .o_step        (w_step)
    );

    krbs_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_q_push),
        .i_wr_data (w_step),
        .i_rd_en   (w_q_pop),
        .o_full    (full),
        .o_vld     (w_q_vld),
        .o_rd_data (w_q_rec)
    );

    krbs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step_vld        (w_q_vld),
        .i_step            (w_q_rec),
        .o_step_pop        (w_q_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_batch_start     (o_batch_start),
        .o_batch_length    (o_batch_length),
        .o_instanced       (o_instanced),
        .o_batch_group_key (o_batch_group_key),
        .o_last_of_step    (o_last_of_step)
    );

    `KRBS_ASSERT_IMP(a_plain_key, !empty && !o_instanced, ~|o_batch_group_key, "keyed plain batch")
    `KRBS_ASSERT_IMP(a_len_nonzero, !empty, o_batch_length != '0, "empty batch emitted")
    `KRBS_ASSERT_IMP(a_full_drop_pop, $fell(full), $past(w_q_pop), "queue left full without pop")
    `KRBS_ASSERT_NXT(a_pop_drains, w_q_pop && !w_q_push && !full, !full, "queue full after drain")

endmodule
`default_nettype wire
